/* src/pqls_pkg.sv */
// Shared constants and types for the linear-scan priority queue.
package pqls_pkg;

  localparam int DEPTH_DEF          = 128;
  localparam int PRIORITY_WIDTH_DEF = 8;
  localparam int VALUE_W            = 32;
  localparam int PRI_W              = 8;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_FULL     = 2'd1,
    ST_DEQUEUED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

endpackage

/* src/pqls_ram.sv */
// Entry store: one write port, one registered read port.
module pqls_ram #(
  parameter int DEPTH = pqls_pkg::DEPTH_DEF,
  parameter int AW    = 7,
  parameter int DW    = 40
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/priority_queue_linear_scan.sv */
// Top level of the linear-scan priority queue.
//
// Input channel (in_valid/in_ready): op selects enqueue or dequeue; item_value and
// item_priority are stored on enqueue. Output channel (out_valid/out_ready) returns
// one result per input transfer: status, out_value, out_priority.
// Enqueue appends at the tail; the result goes through S_RESULT into the output
// register. A full queue rejects with status full, an empty one answers empty.
// Dequeue scans the held entries through the entry RAM read port, one per cycle,
// then closes the gap one entry per cycle. Ties go to the entry inserted first.
// in_ready is high only while the sequencer is idle; one item is in work at a time.
// A finished result sits in the output register, so the next item is taken while
// the receiver stalls; a second result waits until the first transfer completes.
// Reset (rst, synchronous) empties the queue; the RAM itself is not cleared.
module priority_queue_linear_scan #(
  parameter int DEPTH          = pqls_pkg::DEPTH_DEF,
  parameter int PRIORITY_WIDTH = pqls_pkg::PRIORITY_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 op,
  input  logic signed [pqls_pkg::VALUE_W-1:0]  item_value,
  input  logic        [pqls_pkg::PRI_W-1:0]    item_priority,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [1:0]                    status,
  output logic signed [pqls_pkg::VALUE_W-1:0]  out_value,
  output logic        [pqls_pkg::PRI_W-1:0]    out_priority
);

  localparam int PW = (PRIORITY_WIDTH < pqls_pkg::PRI_W) ? PRIORITY_WIDTH : pqls_pkg::PRI_W;
  localparam int VW = pqls_pkg::VALUE_W;
  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = VW + PW;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [CW-1:0]     ptr;
  logic              rd_pend;
  logic [IW-1:0]     rd_idx;
  logic [IW-1:0]     best_idx;
  logic signed [VW-1:0] best_val;
  logic [PW-1:0]     best_pri;
  pqls_pkg::status_t res_status;

  logic              accept;
  logic              take;
  logic              mem_we;
  logic [IW-1:0]     waddr;
  logic [EW-1:0]     wdata;
  logic [EW-1:0]     rd_data;
  logic [PW-1:0]     rd_pri;
  logic signed [VW-1:0] rd_val;

  pqls_ram #(
    .DEPTH (DEPTH),
    .AW    (IW),
    .DW    (EW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ptr[IW-1:0]),
    .rdata (rd_data)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign rd_pri   = rd_data[PW-1:0];
  assign rd_val   = rd_data[EW-1:PW];
  assign take     = rd_pend && ((rd_idx == '0) || (rd_pri < best_pri));

  always_comb begin
    mem_we = 1'b0;
    waddr  = count[IW-1:0];
    wdata  = {item_value, item_priority[PW-1:0]};
    if (accept && (op == pqls_pkg::OP_ENQUEUE) && (count != DEPTH_C)) begin
      mem_we = 1'b1;
    end else if ((state == S_SHIFT) && rd_pend) begin
      mem_we = 1'b1;
      waddr  = rd_idx - IW'(1);
      wdata  = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ptr       <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (op == pqls_pkg::OP_ENQUEUE) begin
              if (count == DEPTH_C) begin
                res_status <= pqls_pkg::ST_FULL;
              end else begin
                count      <= count + CW'(1);
                res_status <= pqls_pkg::ST_ENQUEUED;
              end
              state <= S_RESULT;
            end else if (count == '0) begin
              res_status <= pqls_pkg::ST_EMPTY;
              state      <= S_RESULT;
            end else begin
              ptr     <= '0;
              rd_pend <= 1'b0;
              state   <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (take) begin
            best_idx <= rd_idx;
            best_val <= rd_val;
            best_pri <= rd_pri;
          end
          if (ptr < count) begin
            rd_pend <= 1'b1;
            rd_idx  <= ptr[IW-1:0];
            ptr     <= ptr + CW'(1);
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              ptr   <= CW'(best_idx) + CW'(1);
              state <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (ptr < count) begin
            rd_pend <= 1'b1;
            rd_idx  <= ptr[IW-1:0];
            ptr     <= ptr + CW'(1);
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              count      <= count - CW'(1);
              res_status <= pqls_pkg::ST_DEQUEUED;
              state      <= S_RESULT;
            end
          end
        end
        S_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= res_status;
            if (res_status == pqls_pkg::ST_DEQUEUED) begin
              out_value    <= best_val;
              out_priority <= pqls_pkg::PRI_W'(best_pri);
            end else begin
              out_value    <= '0;
              out_priority <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count above depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_SHIFT) |-> ptr <= count)
    else $error("read pointer past held entries");

  a_shift_addr: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && rd_pend) |-> rd_idx != '0)
    else $error("gap close writes below entry zero");

  a_enq_count: assert property (@(posedge clk) disable iff (rst)
    (accept && op == pqls_pkg::OP_ENQUEUE && count != DEPTH_C)
      |=> count == $past(count) + CW'(1))
    else $error("enqueue did not grow the queue");

  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != pqls_pkg::ST_DEQUEUED)
      |-> (out_value == '0 && out_priority == '0))
    else $error("nonzero payload without dequeue");

endmodule
